/* rtl/rrpq_pkg.sv */
// Shared types and constants for the ranked request priority queue.
`timescale 1ns / 1ps
`default_nettype none
package rrpq_pkg;

    localparam int KEY_W = 39;

    // request type codes
    localparam logic [3:0] TYPE_CFG_RELOAD = 4'd0;
    localparam logic [3:0] TYPE_COMPILE    = 4'd1;
    localparam logic [3:0] TYPE_ADD_PARAM  = 4'd2;
    localparam logic [3:0] TYPE_REM_PARAM  = 4'd3;
    localparam logic [3:0] TYPE_CFG_CHECK  = 4'd4;
    localparam logic [3:0] TYPE_PROBER     = 4'd5;
    localparam logic [3:0] TYPE_EXTRACT    = 4'd6;
    localparam logic [3:0] TYPE_SEARCH     = 4'd7;
    localparam logic [3:0] TYPE_GET_DATA   = 4'd8;
    localparam logic [3:0] TYPE_RESET      = 4'd9;
    localparam logic [3:0] TYPE_CLEAR      = 4'd10;
    localparam logic [3:0] TYPE_OBSERVER   = 4'd11;

    // rank classes, larger is served first
    localparam logic [2:0] CLASS_HIGH     = 3'd4;
    localparam logic [2:0] CLASS_MID      = 3'd3;
    localparam logic [2:0] CLASS_COMPUTED = 3'd2;
    localparam logic [2:0] CLASS_LOW      = 3'd1;
    localparam logic [2:0] CLASS_LOWEST   = 3'd0;

    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_POP = 1'b1;

    typedef logic [KEY_W-1:0] t_key;

    typedef struct packed {
        logic [15:0] tag;
        logic [3:0]  rtype;
        t_key        key;
        logic        unrank;
    } t_entry;

endpackage
`default_nettype wire

/* rtl/ranked_request_priority_queue_top.sv */
// Top level of the ranked request priority queue: sequencer, head pointer and counts.
//
// Usage: drive a request word on the i_ ports and raise start while busy is
// low; the word is taken at that edge. Every word gives one result word,
// shown for exactly one cycle with o_done high; the receiver must take it.
// kind 0 adds an entry, kind 1 pops the head. o_entry_count and o_fifo_mode
// are valid in the o_done cycle.
// Entries live in a circular buffer in one RAM with registered read data;
// an add walks the RAM one entry a cycle, first forward to find the insert
// point, then backward from the tail shifting entries up by one slot.
// A dropped add and an empty pop are answered from idle. An add that lands
// before held entry p makes p + 1 compares and n - p moves, n held entries;
// one that lands at the tail after a full scan makes n compares. In FIFO
// mode or on an empty queue an add goes straight to the tail write.
// busy stays high until the result is shown; the next word may start in the
// o_done cycle. Reset empties the queue and clears FIFO mode at once.
`timescale 1ns / 1ps
`default_nettype none
module ranked_request_priority_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_kind,
    input  wire logic [15:0] i_request_tag,
    input  wire logic [3:0]  i_request_type,
    input  wire logic        i_is_current_inquirer,
    input  wire logic        i_is_current_draw,
    input  wire logic [31:0] i_current_time,
    input  wire logic [31:0] i_first_time,
    input  wire logic [31:0] i_last_time,
    output logic             o_done,
    output logic             o_add_accepted,
    output logic             o_add_dropped,
    output logic             o_pop_valid,
    output logic [15:0]      o_popped_tag,
    output logic [3:0]       o_popped_type,
    output logic [4:0]       o_entry_count,
    output logic             o_fifo_mode
);
    import rrpq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RANK,
        S_SEARCH,
        S_SHIFT,
        S_WRITE,
        S_POP
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_ucount;
    logic [15:0]   r_tag;
    logic [3:0]    r_type;
    t_key          r_key;
    logic          r_unrank;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_pos;
    logic [CW-1:0] r_src;
    logic [CW-1:0] r_widx;
    logic          r_rv;
    logic          r_wv;

    logic          r_done;
    logic          r_add_accepted;
    logic          r_add_dropped;
    logic          r_pop_valid;
    logic [15:0]   r_popped_tag;
    logic [3:0]    r_popped_type;

    logic          accept;
    logic          rank_go;
    logic          rank_valid;
    t_key          rank_key;
    logic          rank_unrank;
    logic [CW-1:0] ucount_new;

    logic          we;
    logic [AW-1:0] waddr;
    t_entry        wdata;
    logic [AW-1:0] raddr;
    t_entry        rdata;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] lidx);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(lidx);
        if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (CW+1)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign accept     = start && !busy;
    assign rank_go    = accept && (i_kind == KIND_ADD) && (r_count != FULL);
    assign ucount_new = r_ucount + CW'(rank_unrank);

    rrpq_rank u_rank (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_go                  (rank_go),
        .i_request_type        (i_request_type),
        .i_is_current_inquirer (i_is_current_inquirer),
        .i_is_current_draw     (i_is_current_draw),
        .i_current_time        (i_current_time),
        .i_first_time          (i_first_time),
        .i_last_time           (i_last_time),
        .o_valid               (rank_valid),
        .o_key                 (rank_key),
        .o_unrank              (rank_unrank)
    );

    rrpq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        case (r_state)
            S_SEARCH: raddr = phys(r_head, CW'(r_idx + 1'b1));
            S_SHIFT:  raddr = phys(r_head, r_src);
            default:  raddr = r_head;
        endcase
    end

    always_comb begin
        we    = 1'b0;
        waddr = phys(r_head, r_widx);
        wdata = rdata;
        case (r_state)
            S_SHIFT: begin
                we = r_wv;
            end
            S_WRITE: begin
                we           = 1'b1;
                waddr        = phys(r_head, r_pos);
                wdata.tag    = r_tag;
                wdata.rtype  = r_type;
                wdata.key    = r_key;
                wdata.unrank = r_unrank;
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_ucount <= '0;
            r_done   <= 1'b0;
            r_rv     <= 1'b0;
            r_wv     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_tag          <= i_request_tag;
                        r_type         <= i_request_type;
                        r_add_accepted <= 1'b0;
                        r_add_dropped  <= 1'b0;
                        r_pop_valid    <= 1'b0;
                        r_popped_tag   <= '0;
                        r_popped_type  <= '0;
                        if (i_kind == KIND_ADD) begin
                            if (r_count == FULL) begin
                                r_add_dropped <= 1'b1;
                                r_done        <= 1'b1;
                            end else begin
                                r_state <= S_RANK;
                            end
                        end else if (r_count == '0) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= S_POP;
                        end
                    end
                end
                S_RANK: begin
                    if (rank_valid) begin
                        r_key    <= rank_key;
                        r_unrank <= rank_unrank;
                        r_ucount <= ucount_new;
                        r_idx    <= '0;
                        if ((ucount_new != '0) || (r_count == '0)) begin
                            r_pos   <= r_count;
                            r_state <= S_WRITE;
                        end else begin
                            r_state <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    if (rdata.key < r_key) begin
                        r_pos   <= r_idx;
                        r_src   <= CW'(r_count - 1'b1);
                        r_rv    <= 1'b1;
                        r_wv    <= 1'b0;
                        r_state <= S_SHIFT;
                    end else if (CW'(r_idx + 1'b1) == r_count) begin
                        r_pos   <= r_count;
                        r_state <= S_WRITE;
                    end else begin
                        r_idx <= CW'(r_idx + 1'b1);
                    end
                end
                S_SHIFT: begin
                    r_wv   <= r_rv;
                    r_widx <= CW'(r_src + 1'b1);
                    if (r_rv) begin
                        if (r_src == r_pos) begin
                            r_rv <= 1'b0;
                        end else begin
                            r_src <= CW'(r_src - 1'b1);
                        end
                    end
                    if (r_wv && !r_rv) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_count        <= CW'(r_count + 1'b1);
                    r_add_accepted <= 1'b1;
                    r_done         <= 1'b1;
                    r_state        <= S_IDLE;
                end
                S_POP: begin
                    r_pop_valid   <= 1'b1;
                    r_popped_tag  <= rdata.tag;
                    r_popped_type <= rdata.rtype;
                    if (rdata.unrank && (r_ucount != '0)) begin
                        r_ucount <= CW'(r_ucount - 1'b1);
                    end
                    r_head  <= (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : AW'(r_head + 1'b1);
                    r_count <= CW'(r_count - 1'b1);
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_add_accepted = r_add_accepted;
    assign o_add_dropped  = r_add_dropped;
    assign o_pop_valid    = r_pop_valid;
    assign o_popped_tag   = r_popped_tag;
    assign o_popped_type  = r_popped_type;
    assign o_entry_count  = 5'(r_count);
    assign o_fifo_mode    = (r_ucount != '0);

endmodule
`default_nettype wire

/* rtl/rrpq_ram.sv */
// Entry store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rrpq_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  rrpq_pkg::t_entry       i_wdata,
    input  wire logic [AW-1:0]     i_raddr,
    output rrpq_pkg::t_entry       o_rdata
);
    import rrpq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/rrpq_rank.sv */
// Two-stage rank key unit: time distances, then class and key assembly.
`timescale 1ns / 1ps
`default_nettype none
module rrpq_rank (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_go,
    input  wire logic [3:0]  i_request_type,
    input  wire logic        i_is_current_inquirer,
    input  wire logic        i_is_current_draw,
    input  wire logic [31:0] i_current_time,
    input  wire logic [31:0] i_first_time,
    input  wire logic [31:0] i_last_time,
    output logic             o_valid,
    output rrpq_pkg::t_key   o_key,
    output logic             o_unrank
);
    import rrpq_pkg::*;

    logic        r_v1;
    logic [3:0]  r_type;
    logic [1:0]  r_tier;
    logic [31:0] r_da;
    logic [31:0] r_db;
    logic        r_inrange;

    logic        r_v2;
    t_key        r_key;
    logic        r_unrank;

    logic [31:0] d;
    logic [2:0]  cls;
    logic [2:0]  s;
    logic        is_data;
    logic        unrank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_go;
        end
        if (i_go) begin
            r_type    <= i_request_type;
            r_tier    <= {i_is_current_inquirer, i_is_current_draw};
            r_da      <= (i_current_time >= i_first_time) ? i_current_time - i_first_time
                                                          : i_first_time - i_current_time;
            r_db      <= (i_current_time >= i_last_time) ? i_current_time - i_last_time
                                                         : i_last_time - i_current_time;
            r_inrange <= (i_first_time <= i_current_time) && (i_current_time <= i_last_time);
        end
    end

    always_comb begin
        d       = r_inrange ? 32'd0 : ((r_da < r_db) ? r_da : r_db);
        s       = 3'd0;
        is_data = 1'b0;
        unrank  = 1'b0;
        case (r_type)
            TYPE_CFG_RELOAD, TYPE_ADD_PARAM, TYPE_REM_PARAM: begin
                cls    = CLASS_LOWEST;
                unrank = 1'b1;
            end
            TYPE_PROBER, TYPE_CLEAR, TYPE_OBSERVER: cls = CLASS_HIGH;
            TYPE_COMPILE, TYPE_RESET:               cls = CLASS_MID;
            TYPE_CFG_CHECK, TYPE_EXTRACT:           cls = CLASS_LOW;
            TYPE_SEARCH: begin
                cls = CLASS_COMPUTED;
                s   = {1'b0, r_tier} + 3'd1;
            end
            TYPE_GET_DATA: begin
                cls     = CLASS_COMPUTED;
                s       = {1'b0, r_tier};
                is_data = 1'b1;
            end
            default: cls = CLASS_LOWEST;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        if (r_v1) begin
            r_unrank <= unrank;
            if (unrank) begin
                r_key <= '0;
            end else begin
                r_key <= {cls, s, is_data, (is_data ? ~d : 32'd0)};
            end
        end
    end

    assign o_valid  = r_v2;
    assign o_key    = r_key;
    assign o_unrank = r_unrank;

endmodule
`default_nettype wire
